// ===== rtl/core/gsa_pkg.sv =====
// gsa_pkg: shared types and codes of the generational slot allocator
// operation, status and result codes, transaction payloads, control/status structs
// no dependencies
package gsa_pkg;

    localparam int HANDLE_W     = 32;
    localparam int RUNS_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int SLOT_INDEX_W = 10;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RUN    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FREE     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RC_OK         = 2'd0,
        RC_NO_FREE    = 2'd1,
        RC_BAD_HANDLE = 2'd2
    } res_code_t;

    // which result the datapath builds when the controller emits
    typedef enum logic [2:0] {
        RS_NO_FREE  = 3'd0,
        RS_BAD      = 3'd1,
        RS_ALLOC    = 3'd2,
        RS_FREE     = 3'd3,
        RS_LOOK_CUR = 3'd4,
        RS_LOOK_IDX = 3'd5,
        RS_RUN      = 3'd6
    } res_sel_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] parent_handle;
        logic                check_perm;
    } gsa_req_t;

    typedef struct packed {
        res_code_t               result_code;
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic                    slot_valid;
        logic [HANDLE_W-1:0]     result_handle;
        logic [RUNS_W-1:0]       run_count;
    } gsa_rsp_t;

    typedef struct packed {
        logic     accept;
        logic     rd_cur;
        logic     rd_idx;
        logic     clr_step;
        logic     wr_alloc;
        logic     wr_free;
        logic     wr_demote;
        logic     wr_run;
        logic     emit;
        res_sel_t res_sel;
    } gsa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic head_null;
        logic in_range;
        logic h_zero;
        logic perm;
        logic cur_valid;
        logic cur_running;
        logic idx_is_cur;
        logic look_match;
        logic parent_match;
        logic out_free;
    } gsa_sts_t;

endpackage

// ===== rtl/core/gsa_ifs.sv =====
// gsa_req_if / gsa_rsp_if: valid/ready channels of the slot allocator
// depends on gsa_pkg for the payload types
interface gsa_req_if;
    import gsa_pkg::*;

    logic     valid;
    logic     ready;
    gsa_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface gsa_rsp_if;
    import gsa_pkg::*;

    logic     valid;
    logic     ready;
    gsa_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/generational_slot_allocator.sv =====
// generational_slot_allocator: top level of the generational slot allocator
// depends on gsa_pkg, gsa_req_if/gsa_rsp_if, gsa_ctrl and gsa_dpath
//
// Hands out NUM_SLOTS slots from a LIFO free list that starts in order 0 to
// NUM_SLOTS-1. Each live slot has a 32-bit handle: a generation from bit
// GEN_SHIFT up and the slot index below. Every request transaction is one
// operation (alloc, free, lookup, run) and yields exactly one response
// transaction. All per-slot state (handle, parent, status, run count, free
// link) sits in one table ram with a registered read port, so each
// operation reads that table and then may write it, one operation at a
// time. A lookup with the permission check on a slot other than the
// current one reads the table a second time to fetch the current slot's
// handle, and run first demotes the old current slot if it is running,
// then reads and updates the target. A run whose index is past the table
// answers without those steps, and so does a lookup that fails before the
// child check (index past the table, stale or free handle, no current
// slot). A response waiting in the output register does not block the
// next request; an operation only stalls at its final step while that
// register is still full. After reset a clearing pass over every entry
// initializes the table and builds the free list; requests are not taken
// during it.
module generational_slot_allocator #(
    parameter int NUM_SLOTS = 1024,
    parameter int GEN_SHIFT = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    gsa_req_if.sink   req,
    gsa_rsp_if.source rsp
);
    import gsa_pkg::*;

    gsa_cmd_t cmd;
    gsa_sts_t sts;

    // sequencing of table reads and writes
    gsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.payload.op),
        .sts       (sts),
        .req_ready (req.ready),
        .cmd       (cmd)
    );

    // slot table, free list head, current slot, response register
    gsa_dpath #(
        .NUM_SLOTS (NUM_SLOTS),
        .GEN_SHIFT (GEN_SHIFT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_payload (req.payload),
        .rsp_ready   (rsp.ready),
        .sts         (sts),
        .rsp_valid   (rsp.valid),
        .rsp_payload (rsp.payload)
    );

    // one operation in flight: no request right after an accepted one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while an operation is in flight");

    // a response is only loaded when the output register can take it
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("response loaded over an unread response");

    // alloc never pops an empty free list
    a_alloc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_alloc |-> !sts.head_null)
        else $error("alloc write with empty free list");

    // at most one table write per cycle
    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.wr_alloc, cmd.wr_free, cmd.wr_demote, cmd.wr_run}))
        else $error("conflicting table writes");
endmodule

// ===== rtl/core/gsa_ram.sv =====
// gsa_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module gsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/gsa_ctrl.sv =====
// gsa_ctrl: sequencing state machine of the slot allocator
// depends on gsa_pkg; drives gsa_dpath through gsa_cmd_t, reads gsa_sts_t
module gsa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  gsa_pkg::op_t      req_op,
    input  gsa_pkg::gsa_sts_t sts,
    output logic              req_ready,
    output gsa_pkg::gsa_cmd_t cmd
);
    import gsa_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_ALLOC    = 9'b000000100,
        S_FREE     = 9'b000001000,
        S_LOOK     = 9'b000010000,
        S_LOOK_PAR = 9'b000100000,
        S_RUN_CUR  = 9'b001000000,
        S_RUN_RD   = 9'b010000000,
        S_RUN_EXE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.res_sel = RS_BAD;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (req_op)
                        OP_ALLOC:  state_next = S_ALLOC;
                        OP_FREE:   state_next = S_FREE;
                        OP_LOOKUP: state_next = S_LOOK;
                        OP_RUN:    state_next = S_RUN_CUR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ALLOC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.head_null)
                    begin
                        cmd.res_sel = RS_NO_FREE;
                    end
                    else
                    begin
                        cmd.wr_alloc = 1'b1;
                        cmd.res_sel  = RS_ALLOC;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FREE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.in_range)
                    begin
                        cmd.wr_free = 1'b1;
                        cmd.res_sel = RS_FREE;
                    end
                    state_next = S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (sts.h_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RS_LOOK_CUR;
                        state_next  = S_IDLE;
                    end
                end
                else if (!sts.in_range || !sts.look_match || (sts.perm && !sts.cur_valid))
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!sts.perm || sts.idx_is_cur)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit    = 1'b1;
                        cmd.res_sel = RS_LOOK_IDX;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    // child check needs the current slot's handle
                    cmd.rd_cur = 1'b1;
                    state_next = S_LOOK_PAR;
                end
            end
            S_LOOK_PAR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.res_sel = sts.parent_match ? RS_LOOK_IDX : RS_BAD;
                    state_next  = S_IDLE;
                end
            end
            S_RUN_CUR:
            begin
                if (!sts.in_range)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.wr_demote = sts.cur_valid && sts.cur_running;
                    state_next    = S_RUN_RD;
                end
            end
            S_RUN_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = S_RUN_EXE;
            end
            S_RUN_EXE:
            begin
                if (sts.out_free)
                begin
                    cmd.wr_run  = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.res_sel = RS_RUN;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/core/gsa_dpath.sv =====
// gsa_dpath: slot table ram, free-list head, current slot and result register
// depends on gsa_pkg and gsa_ram; steered by gsa_ctrl through gsa_cmd_t
module gsa_dpath #(
    parameter int NUM_SLOTS = 1024,
    parameter int GEN_SHIFT = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gsa_pkg::gsa_cmd_t cmd,
    input  gsa_pkg::gsa_req_t req_payload,
    input  logic              rsp_ready,
    output gsa_pkg::gsa_sts_t sts,
    output logic              rsp_valid,
    output gsa_pkg::gsa_rsp_t rsp_payload
);
    import gsa_pkg::*;

    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int PTR_W   = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W   = 2 * HANDLE_W + STATUS_W + RUNS_W + PTR_W;
    localparam int RUNS_LO = PTR_W;
    localparam int STAT_LO = RUNS_LO + RUNS_W;
    localparam int PAR_LO  = STAT_LO + STATUS_W;
    localparam int HND_LO  = PAR_LO + HANDLE_W;

    localparam logic [PTR_W-1:0]    NULL_PTR = PTR_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [HANDLE_W-1:0] GEN_STEP = HANDLE_W'(1) << GEN_SHIFT;
    localparam logic [HANDLE_W-1:0] IDX_MASK = GEN_STEP - HANDLE_W'(1);

    // latched transaction
    logic [HANDLE_W-1:0] h_reg;
    logic [HANDLE_W-1:0] parent_reg;
    logic                perm_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                in_range_reg;
    logic                hzero_reg;

    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    cur_reg;
    logic [HANDLE_W-1:0] par_save_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic                rsp_valid_reg;
    gsa_rsp_t            rsp_reg;

    logic [HANDLE_W-1:0] in_idx_full;
    logic [IDX_W-1:0]    in_idx;
    logic                in_range_c;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    logic [HANDLE_W-1:0] rd_handle;
    logic [HANDLE_W-1:0] rd_parent;
    logic [STATUS_W-1:0] rd_status;
    logic [RUNS_W-1:0]   rd_runs;
    logic [PTR_W-1:0]    rd_next;
    logic [RUNS_W-1:0]   runs_inc;

    logic [HANDLE_W-1:0] gen_sum;
    logic [HANDLE_W-1:0] gen_masked;
    logic [HANDLE_W-1:0] new_handle;
    gsa_rsp_t            res_c;

    assign in_idx_full = req_payload.handle & IDX_MASK;
    assign in_idx      = IDX_W'(in_idx_full);
    assign in_range_c  = in_idx_full < HANDLE_W'(NUM_SLOTS);

    assign rd_handle = ram_rdata[HND_LO +: HANDLE_W];
    assign rd_parent = ram_rdata[PAR_LO +: HANDLE_W];
    assign rd_status = ram_rdata[STAT_LO +: STATUS_W];
    assign rd_runs   = ram_rdata[RUNS_LO +: RUNS_W];
    assign rd_next   = ram_rdata[PTR_W-1:0];
    assign runs_inc  = rd_runs + RUNS_W'(1);

    // next generation, forced to the first one on zero or sign bit
    assign gen_sum    = rd_handle + GEN_STEP;
    assign gen_masked = gen_sum & ~IDX_MASK;
    assign new_handle = ((gen_masked == '0) || gen_masked[HANDLE_W-1]) ?
                        (GEN_STEP | HANDLE_W'(head_reg)) :
                        (gen_masked | HANDLE_W'(head_reg));

    // read port
    always_comb
    begin
        ram_re    = cmd.accept || cmd.rd_cur || cmd.rd_idx;
        ram_raddr = idx_reg;
        if (cmd.accept)
        begin
            case (req_payload.op)
                OP_ALLOC:  ram_raddr = IDX_W'(head_reg);
                OP_FREE:   ram_raddr = in_idx;
                OP_LOOKUP: ram_raddr = (req_payload.handle == '0) ? IDX_W'(cur_reg) : in_idx;
                OP_RUN:    ram_raddr = IDX_W'(cur_reg);
                default:   ram_raddr = in_idx;
            endcase
        end
        else if (cmd.rd_cur)
        begin
            ram_raddr = IDX_W'(cur_reg);
        end
    end

    // write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {rd_handle, rd_parent, rd_status, rd_runs, rd_next};
        if (cmd.clr_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = {HANDLE_W'(0), HANDLE_W'(0), ST_FREE, RUNS_W'(0),
                         PTR_W'(clr_cnt_reg) + PTR_W'(1)};
        end
        else if (cmd.wr_alloc)
        begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(head_reg);
            ram_wdata = {new_handle, parent_reg, ST_RUNNABLE, RUNS_W'(0), rd_next};
        end
        else if (cmd.wr_free)
        begin
            ram_we    = 1'b1;
            ram_wdata = {rd_handle, rd_parent, ST_FREE, rd_runs, head_reg};
        end
        else if (cmd.wr_demote)
        begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(cur_reg);
            ram_wdata = {rd_handle, rd_parent, ST_RUNNABLE, rd_runs, rd_next};
        end
        else if (cmd.wr_run)
        begin
            ram_we    = 1'b1;
            ram_wdata = {rd_handle, rd_parent, ST_RUNNING, runs_inc, rd_next};
        end
    end

    gsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.clr_last     = (clr_cnt_reg == LAST_IDX);
        sts.head_null    = (head_reg >= NULL_PTR);
        sts.in_range     = in_range_reg;
        sts.h_zero       = hzero_reg;
        sts.perm         = perm_reg;
        sts.cur_valid    = (cur_reg < NULL_PTR);
        sts.cur_running  = (rd_status == ST_RUNNING);
        sts.idx_is_cur   = in_range_reg && (PTR_W'(idx_reg) == cur_reg);
        sts.look_match   = (rd_status != ST_FREE) && (rd_handle == h_reg);
        sts.parent_match = (par_save_reg == rd_handle);
        sts.out_free     = !rsp_valid_reg || rsp_ready;
    end

    // result formatting
    always_comb
    begin
        res_c             = '0;
        res_c.result_code = RC_OK;
        case (cmd.res_sel)
            RS_NO_FREE:
            begin
                res_c.result_code = RC_NO_FREE;
            end
            RS_BAD:
            begin
                res_c.result_code = RC_BAD_HANDLE;
            end
            RS_ALLOC:
            begin
                res_c.slot_index    = SLOT_INDEX_W'(head_reg);
                res_c.slot_valid    = 1'b1;
                res_c.result_handle = new_handle;
            end
            RS_FREE:
            begin
                res_c.slot_index    = SLOT_INDEX_W'(idx_reg);
                res_c.slot_valid    = 1'b1;
                res_c.result_handle = rd_handle;
            end
            RS_LOOK_CUR:
            begin
                if (cur_reg < NULL_PTR)
                begin
                    res_c.slot_index    = SLOT_INDEX_W'(cur_reg);
                    res_c.slot_valid    = 1'b1;
                    res_c.result_handle = rd_handle;
                end
            end
            RS_LOOK_IDX:
            begin
                res_c.slot_index    = SLOT_INDEX_W'(idx_reg);
                res_c.slot_valid    = 1'b1;
                res_c.result_handle = h_reg;
            end
            RS_RUN:
            begin
                res_c.slot_index    = SLOT_INDEX_W'(idx_reg);
                res_c.slot_valid    = 1'b1;
                res_c.result_handle = rd_handle;
                res_c.run_count     = runs_inc;
            end
            default:
            begin
                res_c.result_code = RC_BAD_HANDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cur_reg       <= NULL_PTR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.wr_alloc)
            begin
                head_reg <= (rd_next >= NULL_PTR) ? NULL_PTR : rd_next;
            end
            else if (cmd.wr_free)
            begin
                head_reg <= PTR_W'(idx_reg);
            end
            if (cmd.wr_run)
            begin
                cur_reg <= PTR_W'(idx_reg);
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            h_reg        <= req_payload.handle;
            parent_reg   <= req_payload.parent_handle;
            perm_reg     <= req_payload.check_perm;
            idx_reg      <= in_idx;
            in_range_reg <= in_range_c;
            hzero_reg    <= (req_payload.handle == '0);
        end
        if (cmd.rd_cur)
        begin
            par_save_reg <= rd_parent;
        end
        if (cmd.emit)
        begin
            rsp_reg <= res_c;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;
endmodule
